>>> hw/rtl/bba_pkg.sv
// shared types, sizes and helpers of the buddy bitmap allocator
package bba_pkg;

    // arena geometry, both powers of two
    localparam int MIN_BLOCK   = 16;
    localparam int ARENA_BYTES = 4096;

    localparam int MIN_SHIFT   = $clog2(MIN_BLOCK);
    localparam int ARENA_SHIFT = $clog2(ARENA_BYTES);
    localparam int LEAF_W      = ARENA_SHIFT - MIN_SHIFT;     // bits of a leaf position
    localparam int LEVELS      = LEAF_W + 1;
    localparam int LVL_W       = $clog2(LEVELS + 1);
    localparam int NODES       = 2 * (ARENA_BYTES / MIN_BLOCK) - 1;
    localparam int ADDR_W      = $clog2(NODES + 1);
    localparam int BYTES_W     = ARENA_SHIFT + 1;

    // transaction field widths
    localparam int FUNC_W   = 1;
    localparam int SIZE_W   = 13;
    localparam int OFF_W    = 12;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NO_BLOCK  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_A_LVL,
        S_A_RD,
        S_A_CHK,
        S_F_RD,
        S_F_CHK,
        S_DONE
    } t_state;

    // range of node positions at one tree level
    typedef struct packed {
        logic [LEAF_W-1:0] lo;
        logic [LEAF_W-1:0] hi;
    } t_span;

    // heap index of position pos at level lvl
    function automatic logic [ADDR_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [LEAF_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = (ADDR_W'(1) << lvl) - ADDR_W'(1);
        return base + ADDR_W'(pos);
    endfunction

endpackage

>>> hw/rtl/bba_bitmem.sv
// one-bit-wide node busy memory, one write and one registered read port
module bba_bitmem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bba_pkg::ADDR_W-1:0] i_waddr,
    input  logic                       i_wdata,
    input  logic [bba_pkg::ADDR_W-1:0] i_raddr,
    output logic                       o_rdata
);

    logic r_mem [bba_pkg::NODES];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bba_span.sv
// shift unit: positions at one level that overlap a given block
module bba_span (
    input  logic [bba_pkg::LEAF_W-1:0] i_pos,
    input  logic [bba_pkg::LVL_W-1:0]  i_blk_lvl,
    input  logic [bba_pkg::LVL_W-1:0]  i_lvl,
    output bba_pkg::t_span             o_span
);

    logic [bba_pkg::LVL_W-1:0]  up_sh;
    logic [bba_pkg::LVL_W-1:0]  dn_sh;
    logic [bba_pkg::LEAF_W-1:0] ustart;
    logic [bba_pkg::LEAF_W:0]   ulen;
    logic [bba_pkg::LEAF_W-1:0] uend;

    // block extent in leaf units, then scaled to the probed level
    assign up_sh  = bba_pkg::LVL_W'(bba_pkg::LEAF_W) - i_blk_lvl;
    assign dn_sh  = bba_pkg::LVL_W'(bba_pkg::LEAF_W) - i_lvl;
    assign ustart = i_pos << up_sh;
    assign ulen   = (bba_pkg::LEAF_W + 1)'(1) << up_sh;
    assign uend   = ustart + bba_pkg::LEAF_W'(ulen - (bba_pkg::LEAF_W + 1)'(1));

    assign o_span.lo = ustart >> dn_sh;
    assign o_span.hi = uend >> dn_sh;

endmodule

>>> hw/rtl/buddy_bitmap_allocator.sv
// buddy allocator over a heap-ordered busy bitmap, top level
//
// input channel i_valid / o_ready carries one transaction: i_func selects
// allocate or free, i_req_size is the byte count of an allocate and
// i_free_offset the byte offset of a free. output channel o_valid / i_ready
// returns one transaction per request: o_status and o_block_offset.
// one request is worked on at a time; o_ready is high only while idle.
// allocate: the size is first rounded up to a block level, one level at a
// time; then for each candidate block a level step per tree level plus a
// read and a check per node (ancestors, own node, descendants) until a busy
// node is met; a free allocate of the whole arena reads all 511 nodes.
// free: a read and a check per level probed, from the leaf level upward. the
// done state moves the result to the output register; the node memory's
// single read port sets the pace.
// reset (synchronous, i_rst_n low) starts a clearing pass that writes
// every node free, one per cycle, with o_ready low.
// a result waits in the output register while i_ready is low; the next
// request may be accepted meanwhile, and its result holds in the done
// state until the register frees up.
module buddy_bitmap_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bba_pkg::FUNC_W-1:0]   i_func,
    input  logic [bba_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [bba_pkg::OFF_W-1:0]    i_free_offset,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bba_pkg::STATUS_W-1:0] o_status,
    output logic [bba_pkg::OFF_W-1:0]    o_block_offset
);

    bba_pkg::t_state r_state, n_state;

    // control and working registers
    logic [bba_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [bba_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [bba_pkg::LVL_W-1:0]   r_lvl, n_lvl;       // candidate block level
    logic [bba_pkg::LEAF_W-1:0]  r_cand, n_cand;     // candidate position
    logic [bba_pkg::LVL_W-1:0]   r_d, n_d;           // level being probed
    logic [bba_pkg::LEAF_W-1:0]  r_pos, n_pos;       // position being probed
    logic [bba_pkg::LEAF_W-1:0]  r_hi, n_hi;         // last position at this level
    bba_pkg::t_status            r_status, n_status;
    logic [bba_pkg::OFF_W-1:0]   r_off, n_off;

    // output register
    logic                        r_ovalid, n_ovalid;
    bba_pkg::t_status            r_ostatus, n_ostatus;
    logic [bba_pkg::OFF_W-1:0]   r_ooff, n_ooff;

    // memory and shift unit
    logic                        mem_we;
    logic [bba_pkg::ADDR_W-1:0]  mem_waddr;
    logic                        mem_wdata;
    logic [bba_pkg::ADDR_W-1:0]  mem_raddr;
    logic                        mem_rdata;
    bba_pkg::t_span              span;

    logic                        in_txn;
    logic                        out_free;
    logic                        size_bad;
    logic                        off_bad;
    logic [bba_pkg::BYTES_W-1:0] blk_bytes;
    logic [bba_pkg::LEAF_W-1:0]  cand_last;
    logic                        lvl_leaf;

    bba_bitmem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bba_span u_span (
        .i_pos     (r_cand),
        .i_blk_lvl (r_lvl),
        .i_lvl     (r_d),
        .o_span    (span)
    );

    assign o_ready        = (r_state == bba_pkg::S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_block_offset = r_ooff;

    assign in_txn   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;

    // zero or oversize request
    assign size_bad = (i_req_size == '0) || (32'(i_req_size) > bba_pkg::ARENA_BYTES);
    assign off_bad  = (32'(i_free_offset) >= bba_pkg::ARENA_BYTES);

    // block size at the current candidate level
    assign blk_bytes = bba_pkg::BYTES_W'(bba_pkg::MIN_BLOCK)
                       << (bba_pkg::LVL_W'(bba_pkg::LEAF_W) - r_lvl);
    assign cand_last = bba_pkg::LEAF_W'(((bba_pkg::LEAF_W + 1)'(1) << r_lvl)
                       - (bba_pkg::LEAF_W + 1)'(1));
    assign lvl_leaf  = (r_d == bba_pkg::LVL_W'(bba_pkg::LEAF_W));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                if (r_clr_addr == bba_pkg::ADDR_W'(bba_pkg::NODES - 1)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (in_txn) begin
                    if (i_func == bba_pkg::FN_FREE) begin
                        n_state = off_bad ? bba_pkg::S_DONE : bba_pkg::S_F_RD;
                    end else begin
                        n_state = size_bad ? bba_pkg::S_DONE : bba_pkg::S_SIZE;
                    end
                end
            end
            bba_pkg::S_SIZE: begin
                if (32'(blk_bytes) >= 32'(r_size)) begin
                    n_state = bba_pkg::S_A_LVL;
                end
            end
            bba_pkg::S_A_LVL: n_state = bba_pkg::S_A_RD;
            bba_pkg::S_A_RD:  n_state = bba_pkg::S_A_CHK;
            bba_pkg::S_A_CHK: begin
                if (mem_rdata) begin
                    n_state = (r_cand == cand_last) ? bba_pkg::S_DONE : bba_pkg::S_A_LVL;
                end else if (r_pos != r_hi) begin
                    n_state = bba_pkg::S_A_RD;
                end else if (lvl_leaf) begin
                    n_state = bba_pkg::S_DONE;
                end else begin
                    n_state = bba_pkg::S_A_LVL;
                end
            end
            bba_pkg::S_F_RD: n_state = bba_pkg::S_F_CHK;
            bba_pkg::S_F_CHK: begin
                if (mem_rdata || r_d == '0) begin
                    n_state = bba_pkg::S_DONE;
                end else begin
                    n_state = bba_pkg::S_F_RD;
                end
            end
            bba_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: n_state = bba_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_size     = r_size;
        n_lvl      = r_lvl;
        n_cand     = r_cand;
        n_d        = r_d;
        n_pos      = r_pos;
        n_hi       = r_hi;
        n_status   = r_status;
        n_off      = r_off;
        n_ovalid   = r_ovalid;
        n_ostatus  = r_ostatus;
        n_ooff     = r_ooff;
        mem_we     = 1'b0;
        mem_waddr  = bba_pkg::node_addr(r_d, span.lo);
        mem_wdata  = 1'b0;
        mem_raddr  = bba_pkg::node_addr(r_d, r_pos);

        // output transaction taken
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            bba_pkg::S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + bba_pkg::ADDR_W'(1);
            end
            bba_pkg::S_IDLE: begin
                if (in_txn) begin
                    n_status = bba_pkg::ST_OK;
                    n_off    = '0;
                    n_size   = i_req_size;
                    n_lvl    = bba_pkg::LVL_W'(bba_pkg::LEAF_W);
                    if (i_func == bba_pkg::FN_FREE) begin
                        // probe from the leaf level upward
                        n_cand = bba_pkg::LEAF_W'(i_free_offset >> bba_pkg::MIN_SHIFT);
                        n_d    = bba_pkg::LVL_W'(bba_pkg::LEAF_W);
                        if (off_bad) begin
                            n_status = bba_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        n_cand = '0;
                        n_d    = '0;
                        if (size_bad) begin
                            n_status = bba_pkg::ST_BAD_SIZE;
                        end
                    end
                end
            end
            bba_pkg::S_SIZE: begin
                // round up: one level larger per cycle
                if (32'(blk_bytes) < 32'(r_size)) begin
                    n_lvl = r_lvl - bba_pkg::LVL_W'(1);
                end
            end
            bba_pkg::S_A_LVL: begin
                n_pos = span.lo;
                n_hi  = span.hi;
            end
            bba_pkg::S_A_RD: begin
                mem_raddr = bba_pkg::node_addr(r_d, r_pos);
            end
            bba_pkg::S_A_CHK: begin
                if (mem_rdata) begin
                    // overlap found, move on to the next candidate, or fail after the last
                    if (r_cand == cand_last) begin
                        n_status = bba_pkg::ST_NO_BLOCK;
                    end else begin
                        n_cand = r_cand + bba_pkg::LEAF_W'(1);
                        n_d    = '0;
                    end
                end else if (r_pos != r_hi) begin
                    n_pos = r_pos + bba_pkg::LEAF_W'(1);
                end else if (lvl_leaf) begin
                    // whole path and subtree clear: take it
                    mem_we    = 1'b1;
                    mem_waddr = bba_pkg::node_addr(r_lvl, r_cand);
                    mem_wdata = 1'b1;
                    n_off     = bba_pkg::OFF_W'(32'(r_cand)
                                << (bba_pkg::MIN_SHIFT + bba_pkg::LEAF_W - int'(r_lvl)));
                end else begin
                    n_d = r_d + bba_pkg::LVL_W'(1);
                end
            end
            bba_pkg::S_F_RD: begin
                mem_raddr = bba_pkg::node_addr(r_d, span.lo);
            end
            bba_pkg::S_F_CHK: begin
                if (mem_rdata) begin
                    mem_we    = 1'b1;
                    mem_waddr = bba_pkg::node_addr(r_d, span.lo);
                    mem_wdata = 1'b0;
                end else if (r_d == '0) begin
                    n_status = bba_pkg::ST_NOT_FOUND;
                end else begin
                    n_d = r_d - bba_pkg::LVL_W'(1);
                end
            end
            bba_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ooff    = r_off;
                end
            end
            default: begin
                n_clr_addr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bba_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ovalid   <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_lvl     <= n_lvl;
        r_cand    <= n_cand;
        r_d       <= n_d;
        r_pos     <= n_pos;
        r_hi      <= n_hi;
        r_status  <= n_status;
        r_off     <= n_off;
        r_ostatus <= n_ostatus;
        r_ooff    <= n_ooff;
    end

endmodule

>>> hw/rtl/bba_checker.sv
// port-level checks of the buddy bitmap allocator, bound to the top level
module bba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [bba_pkg::STATUS_W-1:0] o_status,
    input logic [bba_pkg::OFF_W-1:0]    o_block_offset
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_block_offset))
        else $error("result changed while stalled");

    // only a successful request carries an offset
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bba_pkg::ST_OK |-> o_block_offset == '0)
        else $error("offset on failed request");

    // one request at a time
    a_one_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after a request");

    // reset starts the clearing pass with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("busy after reset");

endmodule

bind buddy_bitmap_allocator bba_checker u_bba_checker (.*);

>>> sim/tb_buddy_bitmap_allocator.sv
// self-checking testbench of the buddy bitmap allocator: directed table, then random traffic
`timescale 1ns / 1ps

module tb_buddy_bitmap_allocator;

    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 1680;
    // limit covers the worst allocate, which scans every candidate of a level,
    // plus output stalls and the clearing pass after reset
    localparam longint CYCLE_LIMIT = longint'(N_DIRECTED + N_RANDOM) * 40000 + 2000;
    localparam int SETTLE_CYCLES = 600;
    localparam int MAX_REPORTS   = 10;

    // one row of the directed table; with_exp marks a result typed in by hand
    typedef struct packed {
        bba_pkg::t_func              fn;
        logic [bba_pkg::SIZE_W-1:0]  size;
        logic [bba_pkg::OFF_W-1:0]   offs;
        bit                          with_exp;
        bba_pkg::t_status            st;
        logic [bba_pkg::OFF_W-1:0]   boff;
    } t_stim_row;

    typedef struct {
        bba_pkg::t_status            st;
        logic [bba_pkg::OFF_W-1:0]   boff;
    } t_alloc_reply;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [bba_pkg::FUNC_W-1:0]     i_func;
    logic [bba_pkg::SIZE_W-1:0]     i_req_size;
    logic [bba_pkg::OFF_W-1:0]      i_free_offset;
    logic                           o_valid;
    logic                           i_ready;
    logic [bba_pkg::STATUS_W-1:0]   o_status;
    logic [bba_pkg::OFF_W-1:0]      o_block_offset;

    // predictor state: one busy flag per heap node, plus the blocks now handed out
    bit              node_taken [bba_pkg::NODES];
    int              held_offs[$];
    int              held_size[$];
    t_alloc_reply    awaited_replies[$];

    int   mismatches;
    bit   steady;          // both sides stop idling while set
    longint cycle_count;

    // directed table, walked in order right after reset
    t_stim_row script [N_DIRECTED] = '{
        // zero size and oversize, the largest field value too
        '{bba_pkg::FN_ALLOC,    13'd0,    12'd0, 1'b1, bba_pkg::ST_BAD_SIZE,  12'd0},
        '{bba_pkg::FN_ALLOC, 13'd4097,    12'd0, 1'b1, bba_pkg::ST_BAD_SIZE,  12'd0},
        '{bba_pkg::FN_ALLOC, 13'd8191,    12'd0, 1'b1, bba_pkg::ST_BAD_SIZE,  12'd0},
        // free on an empty arena finds nothing, size field ignored
        '{bba_pkg::FN_FREE,  13'd8191,    12'd0, 1'b1, bba_pkg::ST_NOT_FOUND, 12'd0},
        '{bba_pkg::FN_FREE,     13'd0, 12'd4095, 1'b1, bba_pkg::ST_NOT_FOUND, 12'd0},
        // whole arena, then anything fails on the busy root
        '{bba_pkg::FN_ALLOC, 13'd4096, 12'd4095, 1'b1, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC,    13'd1, 12'd4095, 1'b1, bba_pkg::ST_NO_BLOCK,  12'd0},
        // unaligned free walks up to the root
        '{bba_pkg::FN_FREE,     13'd0,  12'd100, 1'b1, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC,    13'd1,    12'd0, 1'b1, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC,   13'd16,    12'd0, 1'b1, bba_pkg::ST_OK,        12'd16},
        '{bba_pkg::FN_ALLOC,   13'd17,    12'd0, 1'b1, bba_pkg::ST_OK,        12'd32},
        // busy descendants block the root
        '{bba_pkg::FN_ALLOC, 13'd4096,    12'd0, 1'b1, bba_pkg::ST_NO_BLOCK,  12'd0},
        '{bba_pkg::FN_ALLOC, 13'd2048,    12'd0, 1'b0, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC, 13'd2048,    12'd0, 1'b1, bba_pkg::ST_NO_BLOCK,  12'd0},
        '{bba_pkg::FN_FREE,     13'd0, 12'd2050, 1'b1, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_FREE,     13'd0, 12'd2048, 1'b1, bba_pkg::ST_NOT_FOUND, 12'd0},
        '{bba_pkg::FN_FREE,     13'd0,    12'd5, 1'b1, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC,    13'd8,    12'd0, 1'b0, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC, 13'd4095,    12'd0, 1'b1, bba_pkg::ST_NO_BLOCK,  12'd0},
        '{bba_pkg::FN_ALLOC, 13'd1024,    12'd0, 1'b0, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_FREE,     13'd0,   12'd40, 1'b0, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_FREE,     13'd0, 12'd4095, 1'b1, bba_pkg::ST_NOT_FOUND, 12'd0},
        '{bba_pkg::FN_ALLOC,   13'd32,    12'd0, 1'b0, bba_pkg::ST_OK,        12'd0},
        '{bba_pkg::FN_ALLOC,    13'd2,    12'd0, 1'b0, bba_pkg::ST_OK,        12'd0}
    };

    buddy_bitmap_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_block_offset (o_block_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // true when no node above idx is busy
    function automatic bit path_clear(input int idx);
        int n;
        n = idx;
        while (n > 0) begin
            n = (n - 1) / 2;
            if (node_taken[n]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // true when idx and every node below it are free, walked level by level
    function automatic bit subtree_clear(input int idx);
        int lo;
        int hi;
        lo = idx;
        hi = idx;
        while (lo < bba_pkg::NODES) begin
            for (int k = lo; k <= hi; k++)
                if (k < bba_pkg::NODES && node_taken[k]) return 1'b0;
            lo = 2 * lo + 1;
            hi = 2 * hi + 2;
        end
        return 1'b1;
    endfunction

    // heap index of the block of size blk at byte offset offs
    function automatic int heap_node(input int blk, input int offs);
        return offs / blk + bba_pkg::ARENA_BYTES / blk - 1;
    endfunction

    // works out the reply to one request and updates the busy map
    function automatic void allocator_reply(input bba_pkg::t_func fn, input int sz,
                                            input int offs, output t_alloc_reply rep);
        int  blk;
        int  node;
        bit  done;
        rep.st   = bba_pkg::ST_OK;
        rep.boff = '0;
        done     = 1'b0;
        if (fn == bba_pkg::FN_ALLOC) begin
            if (sz == 0 || sz > bba_pkg::ARENA_BYTES) begin
                rep.st = bba_pkg::ST_BAD_SIZE;
            end else begin
                // round up to a power of two, never under the minimum block
                blk = bba_pkg::MIN_BLOCK;
                while (blk < sz) blk = blk * 2;
                rep.st = bba_pkg::ST_NO_BLOCK;
                if (blk <= bba_pkg::ARENA_BYTES) begin
                    // lowest offset first; stop at the arena end
                    for (int o = 0; o < bba_pkg::ARENA_BYTES && !done; o += blk) begin
                        node = heap_node(blk, o);
                        if (subtree_clear(node) && path_clear(node)) begin
                            node_taken[node] = 1'b1;
                            rep.st   = bba_pkg::ST_OK;
                            rep.boff = bba_pkg::OFF_W'(o);
                            held_offs.push_back(o);
                            held_size.push_back(blk);
                            done = 1'b1;
                        end
                    end
                end
            end
        end else begin
            rep.st = bba_pkg::ST_NOT_FOUND;
            if (offs < bba_pkg::ARENA_BYTES) begin
                // smallest busy block covering the offset wins
                for (blk = bba_pkg::MIN_BLOCK; blk <= bba_pkg::ARENA_BYTES && !done;
                     blk = blk * 2) begin
                    node = heap_node(blk, offs);
                    if (node_taken[node]) begin
                        node_taken[node] = 1'b0;
                        rep.st = bba_pkg::ST_OK;
                        done   = 1'b1;
                    end
                end
            end
            // busy blocks never overlap, so exactly one held entry covers it
            if (done) begin
                for (int i = 0; i < held_offs.size(); i++) begin
                    if (offs >= held_offs[i] && offs < held_offs[i] + held_size[i]) begin
                        held_offs.delete(i);
                        held_size.delete(i);
                        break;
                    end
                end
            end
        end
    endfunction

    // presents one request transaction, called at a falling edge, returns at one
    task automatic send_request(input bba_pkg::t_func fn,
                                input logic [bba_pkg::SIZE_W-1:0] sz,
                                input logic [bba_pkg::OFF_W-1:0] offs, input bit with_exp,
                                input bba_pkg::t_status st_exp,
                                input logic [bba_pkg::OFF_W-1:0] boff_exp);
        t_alloc_reply rep;
        bit taken;
        // random gaps before the transaction
        while (!steady && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= fn;
        i_req_size    <= sz;
        i_free_offset <= offs;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_ready;
        end
        // predictor runs on every accepted request to keep its map in step
        allocator_reply(fn, int'(sz), int'(offs), rep);
        if (with_exp) begin
            rep.st   = st_exp;
            rep.boff = boff_exp;
        end
        awaited_replies.push_back(rep);
        @(negedge i_clk);
    endtask

    // request size that rounds to a block of 2**lvl bytes
    function automatic int size_for_level(input int lvl);
        if (lvl <= bba_pkg::MIN_SHIFT) return $urandom_range(bba_pkg::MIN_BLOCK, 1);
        return $urandom_range(1 << lvl, (1 << (lvl - 1)) + 1);
    endfunction

    // random block level, weighted toward small sizes
    function automatic int pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 4;
        if (r < 30) return 5;
        if (r < 45) return 6;
        if (r < 60) return 7;
        if (r < 72) return 8;
        if (r < 82) return 9;
        if (r < 90) return 10;
        if (r < 96) return 11;
        return 12;
    endfunction

    // result channel: random back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 26);
    end

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_replies.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result transaction: status %0d offset %0d",
                             o_status, o_block_offset);
                mismatches++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.st || o_block_offset !== want.boff) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"mismatch: expected status %0d offset %0d,",
                                  " got status %0d offset %0d"},
                                 want.st, want.boff, o_status, o_block_offset);
                    mismatches++;
                end
            end
        end
    end

    // timeout
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int          r;
        int          pick;
        int          offs;
        int          sz;
        bit          grow;
        int          free_pct;
        mismatches    = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = bba_pkg::FN_ALLOC;
        i_req_size    = '0;
        i_free_offset = '0;
        for (int n = 0; n < bba_pkg::NODES; n++) node_taken[n] = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        for (int i = 0; i < N_DIRECTED; i++)
            send_request(script[i].fn, script[i].size, script[i].offs,
                         script[i].with_exp, script[i].st, script[i].boff);

        // random part: grow and shrink phases of alloc / free traffic, some noise
        for (int k = 0; k < N_RANDOM; k++) begin
            steady   = (k >= 600 && k < 900);
            grow     = ((k / 100) % 2 == 0);
            free_pct = grow ? 25 : 70;
            r = $urandom_range(99);
            if (r < 4) begin
                // bad size: zero or above the arena
                sz = $urandom_range(1) ? 0 : $urandom_range(8191, bba_pkg::ARENA_BYTES + 1);
                send_request(bba_pkg::FN_ALLOC, bba_pkg::SIZE_W'(sz),
                             bba_pkg::OFF_W'($urandom), 1'b0, bba_pkg::ST_OK, '0);
            end else if (r < 9) begin
                // free at an arbitrary offset, often hits nothing
                send_request(bba_pkg::FN_FREE, bba_pkg::SIZE_W'($urandom),
                             bba_pkg::OFF_W'($urandom_range(bba_pkg::ARENA_BYTES - 1)),
                             1'b0, bba_pkg::ST_OK, '0);
            end else if (held_offs.size() != 0 && $urandom_range(99) < free_pct) begin
                // free a block that is held, sometimes at an unaligned offset inside it
                pick = $urandom_range(held_offs.size() - 1);
                offs = held_offs[pick];
                if ($urandom_range(1)) offs += $urandom_range(held_size[pick] - 1);
                send_request(bba_pkg::FN_FREE, bba_pkg::SIZE_W'($urandom),
                             bba_pkg::OFF_W'(offs), 1'b0, bba_pkg::ST_OK, '0);
            end else begin
                sz = size_for_level(pick_level());
                send_request(bba_pkg::FN_ALLOC, bba_pkg::SIZE_W'(sz),
                             bba_pkg::OFF_W'($urandom), 1'b0, bba_pkg::ST_OK, '0);
            end
        end
        steady  = 1'b0;
        i_valid <= 1'b0;

        // drain, then give a stray result time to show up
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> buddy_bitmap_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_bitmem.sv
hw/rtl/bba_span.sv
hw/rtl/buddy_bitmap_allocator.sv
hw/rtl/bba_checker.sv
sim/tb_buddy_bitmap_allocator.sv
